### rtl/core/lsfx_pkg.sv
// shared types and constants for the led strip effect generator
package lsfx_pkg;

   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] FULL_SCALE = 8'd255;
   localparam logic [COUNT_W-1:0] MIN_LEDS = 7'd2;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // effect modes
   localparam logic [2:0] MODE_CLEAR = 3'd0;
   localparam logic [2:0] MODE_FILL = 3'd1;
   localparam logic [2:0] MODE_FADE = 3'd2;
   localparam logic [2:0] MODE_WIPE = 3'd3;
   localparam logic [2:0] MODE_MIDDLE = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_EFFECT_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LED_COUNT = 2'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic frame_last;
      logic advance_color;
   } rsp_word_type;

   // one frame as handed from front to back: lit spans are [lo,hi)
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] lo1;
      logic [COUNT_W-1:0] hi1;
      logic [COUNT_W-1:0] lo2;
      logic [COUNT_W-1:0] hi2;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic advance;
   } frame_desc_type;

endpackage

### rtl/core/lsfx_front.sv
// front end: config registers, frame counter update and frame classification
module lsfx_front import lsfx_pkg::*; #(
   parameter int MAX_LEDS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_word_type req_word,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic q_push,
   output frame_desc_type q_din,
   input  logic q_full
);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} state_type;

   state_type state_ff;
   logic [2:0] mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [7:0] fc_ff, fc_in;
   logic down_ff, down_in;

   req_word_type col_ff;
   logic [7:0] ic_ff;
   logic fade_ff;
   frame_desc_type desc_ff;
   logic [15:0] prod_r_ff, prod_g_ff, prod_b_ff;

   logic [COUNT_W-1:0] n_sat, mid, off;
   logic [7:0] hi_lim, ic, stepped;
   logic at_hi, at_lo;
   frame_desc_type desc_in;
   logic accept;

   // floor(p / 255) for p up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return s[15:8];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;
   assign q_push = (state_ff == S_PUSH) && !q_full;

   // saturated led count, per-mode limit and clamped counter
   always_comb begin
      if (count_ff < MIN_LEDS) begin
         n_sat = MIN_LEDS;
      end else if (count_ff > COUNT_W'(MAX_LEDS)) begin
         n_sat = COUNT_W'(MAX_LEDS);
      end else begin
         n_sat = count_ff;
      end
      mid = n_sat >> 1;
      case (mode_ff)
         MODE_WIPE: hi_lim = {n_sat, 1'b0};
         MODE_MIDDLE: hi_lim = {1'b0, n_sat};
         default: hi_lim = FULL_SCALE;
      endcase
      ic = (fc_ff > hi_lim) ? hi_lim : fc_ff;
      off = COUNT_W'(ic) - mid;
   end

   // saturating step toward the current direction
   always_comb begin
      if (down_ff) begin
         stepped = (ic != 8'd0) ? ic - 8'd1 : 8'd0;
      end else begin
         stepped = (ic < hi_lim) ? ic + 8'd1 : hi_lim;
      end
      at_hi = (stepped == hi_lim);
      at_lo = (stepped == 8'd0);
   end

   // lit spans, advance flag and next counter state per mode
   always_comb begin
      desc_in = '0;
      desc_in.count = n_sat;
      fc_in = fc_ff;
      down_in = down_ff;
      case (mode_ff)
         MODE_FILL: begin
            desc_in.hi1 = n_sat;
            if (ic == FULL_SCALE) begin
               fc_in = 8'd1;
               desc_in.advance = 1'b1;
            end else begin
               fc_in = ic + 8'd1;
            end
         end
         MODE_FADE: begin
            desc_in.hi1 = n_sat;
            fc_in = stepped;
            if (at_hi) begin
               down_in = !down_ff;
            end else if (at_lo) begin
               down_in = !down_ff;
               desc_in.advance = 1'b1;
            end
         end
         MODE_WIPE: begin
            if (ic > {1'b0, n_sat}) begin
               desc_in.lo1 = COUNT_W'(ic - {1'b0, n_sat});
               desc_in.hi1 = n_sat;
            end else begin
               desc_in.hi1 = COUNT_W'(ic);
            end
            fc_in = stepped;
            if (at_hi || at_lo) begin
               down_in = !down_ff;
               desc_in.advance = 1'b1;
            end
         end
         MODE_MIDDLE: begin
            if (COUNT_W'(ic) > mid) begin
               if ({1'b0, n_sat} > {off, 1'b0}) begin
                  desc_in.lo1 = off;
                  desc_in.hi1 = n_sat - off;
               end
            end else begin
               desc_in.hi1 = COUNT_W'(ic);
               desc_in.lo2 = n_sat - COUNT_W'(ic);
               desc_in.hi2 = n_sat;
            end
            fc_in = stepped;
            if (at_hi || at_lo) begin
               down_in = !down_ff;
               desc_in.advance = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // descriptor to the queue, fade colours scaled here
   always_comb begin
      q_din = desc_ff;
      if (fade_ff) begin
         q_din.red = div255(prod_r_ff);
         q_din.green = div255(prod_g_ff);
         q_din.blue = div255(prod_b_ff);
      end else begin
         q_din.red = col_ff.red;
         q_din.green = col_ff.green;
         q_din.blue = col_ff.blue;
      end
   end

   // sequencer, config registers and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= MODE_CLEAR;
         count_ff <= COUNT_RESET;
         fc_ff <= 8'd0;
         down_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_EFFECT_MODE: mode_ff <= csr_data[2:0];
               REG_LED_COUNT: count_ff <= csr_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  col_ff <= req_word;
                  ic_ff <= ic;
                  fade_ff <= (mode_ff == MODE_FADE);
                  desc_ff <= desc_in;
                  fc_ff <= fc_in;
                  down_ff <= down_in;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_r_ff <= {8'd0, col_ff.red} * {8'd0, ic_ff};
               prod_g_ff <= {8'd0, col_ff.green} * {8'd0, ic_ff};
               prod_b_ff <= {8'd0, col_ff.blue} * {8'd0, ic_ff};
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (!q_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/lsfx_queue.sv
// two-entry queue of frame descriptors between front and back
module lsfx_queue import lsfx_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  frame_desc_type din,
   output logic full,
   input  logic pop,
   output frame_desc_type dout,
   output logic empty
);

   frame_desc_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign dout = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

### rtl/core/lsfx_back.sv
// back end: walks one frame descriptor and emits one pixel word per cycle unless stalled
module lsfx_back import lsfx_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  frame_desc_type q_dout,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_word_type rsp_word
);

   frame_desc_type cur_ff;
   logic cur_valid_ff;
   logic [COUNT_W-1:0] k_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic out_load, lit, last;
   rsp_word_type pixel;

   assign q_pop = !q_empty && !cur_valid_ff;
   assign out_load = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   // pixel k of the current frame
   always_comb begin
      lit = ((k_ff >= cur_ff.lo1) && (k_ff < cur_ff.hi1)) ||
            ((k_ff >= cur_ff.lo2) && (k_ff < cur_ff.hi2));
      last = (k_ff == cur_ff.count - 7'd1);
      pixel.led_index = k_ff[INDEX_W-1:0];
      pixel.pixel_red = lit ? cur_ff.red : 8'd0;
      pixel.pixel_green = lit ? cur_ff.green : 8'd0;
      pixel.pixel_blue = lit ? cur_ff.blue : 8'd0;
      pixel.frame_last = last;
      pixel.advance_color = last && cur_ff.advance;
   end

   // frame walk and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         if (q_pop) begin
            cur_ff <= q_dout;
            cur_valid_ff <= 1'b1;
            k_ff <= '0;
         end
         if (out_load) begin
            rsp_word_ff <= pixel;
            rsp_valid_ff <= 1'b1;
            k_ff <= k_ff + 7'd1;
            if (last) begin
               cur_valid_ff <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### rtl/core/led_strip_effect_generator_core.sv
// LED strip effect generator top level: one frame tick in, one pixel word per LED out.
// Each accepted frame tick yields N pixel words (N = led_count saturated to 2..MAX_LEDS),
// leaving from the back end's output register at one word per cycle while the receiver is
// ready. The front end steps through classify, multiply and scale for each tick and overlaps
// the previous frame through a two-entry descriptor queue, so the sustained rate is set by
// the back end's pixel walk. The frame counter updates when a tick is taken.
module led_strip_effect_generator_core import lsfx_pkg::*; #(
   parameter int MAX_LEDS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_word_type rsp_word,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic q_push, q_full, q_pop, q_empty;
   frame_desc_type q_din, q_dout;

   // front end
   lsfx_front #(
      .MAX_LEDS(MAX_LEDS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .q_push(q_push),
      .q_din(q_din),
      .q_full(q_full)
   );

   // descriptor queue
   lsfx_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .din(q_din),
      .full(q_full),
      .pop(q_pop),
      .dout(q_dout),
      .empty(q_empty)
   );

   // back end
   lsfx_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_dout(q_dout),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   // queue is never written while full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("descriptor pushed into full queue");

   // queue is never read while empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("descriptor popped from empty queue");

   // after the last word of a frame the next word starts at index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_word.frame_last) |=>
      (!rsp_valid || rsp_word.led_index == '0))
      else $error("frame did not restart at index zero");

   // inside a frame the index steps by one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_word.frame_last) |=>
      (!rsp_valid || rsp_word.led_index == INDEX_W'($past(rsp_word.led_index) + 1)))
      else $error("pixel index skipped within a frame");

endmodule

### tb/sv/led_strip_effect_generator_checker.sv
// pixel predictor and scoreboard for the led strip effect generator
`timescale 1ns / 100ps
module led_strip_effect_generator_checker import lsfx_pkg::*; #(
   parameter int MAX_LEDS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_word_type req_word,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_word_type rsp_word,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic end_of_run,
   output int mismatch_count,
   output int pixels_pending,
   output logic [7:0] frame_count_now,
   output logic counting_down_now
);

   // shadow copy of the registers and the effect state
   logic [2:0] mode_q;
   logic [COUNT_W-1:0] count_q;
   logic [7:0] frame_ctr;
   logic going_down;

   rsp_word_type expected_pixels[$];
   rsp_word_type oldest_pixel;
   int errors = 0;
   int frames_seen = 0;
   int pixels_checked = 0;
   int advance_seen = 0;
   int reg_writes = 0;
   bit closed = 1'b0;

   function automatic int field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // build the pixel words of one frame tick and step the effect state
   function automatic void render_frame(req_word_type w);
      int n, i, top, lo1, hi1, lo2, hi2, mid, off, r, g, b, k;
      bit bounce, adv, lit;
      rsp_word_type px;
      n = int'(count_q);
      if (n < int'(MIN_LEDS)) n = int'(MIN_LEDS);
      if (n > MAX_LEDS) n = MAX_LEDS;
      i = int'(frame_ctr);
      r = int'(w.red);
      g = int'(w.green);
      b = int'(w.blue);
      lo1 = 0;
      hi1 = 0;
      lo2 = 0;
      hi2 = 0;
      top = 0;
      bounce = 1'b0;
      adv = 1'b0;
      case (mode_q)
         MODE_FILL: begin
            // wraps at full scale and asks for the next colour
            hi1 = n;
            if (i == int'(FULL_SCALE)) begin
               i = 0;
               adv = 1'b1;
            end
            i = i + 1;
         end
         MODE_FADE: begin
            top = int'(FULL_SCALE);
            r = (r * i) / top;
            g = (g * i) / top;
            b = (b * i) / top;
            hi1 = n;
            bounce = 1'b1;
         end
         MODE_WIPE: begin
            top = 2 * n;
            if (i > top) i = top;
            if (i > n) begin
               lo1 = i - n;
               hi1 = n;
            end else begin
               hi1 = i;
            end
            bounce = 1'b1;
         end
         MODE_MIDDLE: begin
            top = n;
            if (i > top) i = top;
            mid = n / 2;
            if (i > mid) begin
               off = i - mid;
               if (n > 2 * off) begin
                  lo1 = off;
                  hi1 = n - off;
               end
            end else begin
               hi1 = i;
               lo2 = n - i;
               hi2 = n;
            end
            bounce = 1'b1;
         end
         default: begin
            // clear and the unused modes leave every led dark
         end
      endcase

      // saturating step; reaching a limit turns the count around
      if (bounce) begin
         if (going_down) i = (i > 0) ? i - 1 : 0;
         else i = (i < top) ? i + 1 : top;
         if (i == top) begin
            going_down = !going_down;
            adv = (mode_q != MODE_FADE);
         end else if (i == 0) begin
            going_down = !going_down;
            adv = 1'b1;
         end
      end
      frame_ctr = i[7:0];
      frames_seen++;
      if (adv) advance_seen++;

      for (k = 0; k < n; k++) begin
         lit = (k >= lo1 && k < hi1) || (k >= lo2 && k < hi2);
         px.led_index = k[INDEX_W-1:0];
         px.pixel_red = lit ? r[7:0] : 8'd0;
         px.pixel_green = lit ? g[7:0] : 8'd0;
         px.pixel_blue = lit ? b[7:0] : 8'd0;
         px.frame_last = (k == n - 1);
         px.advance_color = (k == n - 1) && adv;
         expected_pixels.push_back(px);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode_q = MODE_CLEAR;
         count_q = COUNT_RESET;
         frame_ctr = '0;
         going_down = 1'b0;
         expected_pixels.delete();
      end else begin
         // accepted pixel word against the oldest expected one
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel word for led %0d", rsp_word.led_index);
               errors++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               errors += field_check("led_index", {2'b00, oldest_pixel.led_index},
                                     {2'b00, rsp_word.led_index});
               errors += field_check("pixel_red", oldest_pixel.pixel_red, rsp_word.pixel_red);
               errors += field_check("pixel_green", oldest_pixel.pixel_green,
                                     rsp_word.pixel_green);
               errors += field_check("pixel_blue", oldest_pixel.pixel_blue, rsp_word.pixel_blue);
               errors += field_check("frame_last", {7'd0, oldest_pixel.frame_last},
                                     {7'd0, rsp_word.frame_last});
               errors += field_check("advance_color", {7'd0, oldest_pixel.advance_color},
                                     {7'd0, rsp_word.advance_color});
               pixels_checked++;
            end
         end

         // register writes
         if (csr_valid && csr_ready) begin
            reg_writes++;
            if (csr_index == REG_EFFECT_MODE) mode_q = csr_data[2:0];
            else if (csr_index == REG_LED_COUNT) count_q = csr_data[COUNT_W-1:0];
         end

         // frame tick taken
         if (req_valid && req_ready) render_frame(req_word);

         // nothing may still be waiting once the run is over
         if (end_of_run && !closed) begin
            closed = 1'b1;
            if (expected_pixels.size() != 0) begin
               $error("%0d expected pixel words never arrived", expected_pixels.size());
               errors += expected_pixels.size();
            end
            $display("covered %0d frame ticks and %0d pixel words over all five effects,",
                     frames_seen, pixels_checked);
            $display("%0d advance pulses, %0d register writes incl. out-of-range values",
                     advance_seen, reg_writes);
         end
      end
      mismatch_count <= errors;
      pixels_pending <= expected_pixels.size();
      frame_count_now <= frame_ctr;
      counting_down_now <= going_down;
   end

endmodule

### tb/sv/led_strip_effect_generator_core_tb.sv
// testbench top for the led strip effect generator: stimulus, flow control and verdict
`timescale 1ns / 100ps
module led_strip_effect_generator_core_tb;
   import lsfx_pkg::*;

   localparam int MAX_LEDS = 64;
   localparam int LONG_STALL = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic end_of_run = 1'b0;

   int mismatch_count;
   int pixels_pending;
   logic [7:0] frame_count_now;
   logic counting_down_now;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_requests = 0;
   int stalls_served = 0;
   int hold_left = 0;
   int ticks_sent = 0;

   led_strip_effect_generator_core #(
      .MAX_LEDS(MAX_LEDS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   led_strip_effect_generator_checker #(
      .MAX_LEDS(MAX_LEDS)
   ) pixel_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .end_of_run(end_of_run),
      .mismatch_count(mismatch_count),
      .pixels_pending(pixels_pending),
      .frame_count_now(frame_count_now),
      .counting_down_now(counting_down_now)
   );

   always #10 clock = ~clock;

   // hard limit on the run
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // pixel receiver: random back-pressure plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stalls_served != stall_requests) begin
         stalls_served <= stalls_served + 1;
         hold_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic req_word_type random_color();
      logic [31:0] bits;
      bits = $urandom;
      return bits[23:0];
   endfunction

   // offer one frame tick word, with random idle cycles ahead of it
   task automatic send_tick(input req_word_type w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   // stop offering and wait until every expected pixel word is out
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] mode_data, input logic [7:0] count_data);
      quiesce();
      csr_write(REG_EFFECT_MODE, mode_data);
      csr_write(REG_LED_COUNT, count_data);
      csr_valid <= 1'b0;
   endtask

   // one random setting followed by a short burst of frame ticks
   task automatic random_segment();
      logic [31:0] bits;
      logic [2:0] mode_sel;
      logic [7:0] mode_data;
      int pick, cnt, len;
      bits = $urandom;
      case ($urandom_range(0, 4))
         0: mode_sel = MODE_CLEAR;
         1: mode_sel = MODE_FILL;
         2: mode_sel = MODE_FADE;
         3: mode_sel = MODE_WIPE;
         default: mode_sel = MODE_MIDDLE;
      endcase
      mode_data = {bits[15:11], mode_sel};
      if ($urandom_range(0, 99) < 10) mode_data = bits[15:8];
      // mostly short strips, a few full ones and some out-of-range counts
      pick = $urandom_range(0, 99);
      if (pick < 55) cnt = $urandom_range(2, 6);
      else if (pick < 75) cnt = $urandom_range(7, 64);
      else if (pick < 85) cnt = 64;
      else if (pick < 92) cnt = $urandom_range(0, 1);
      else cnt = $urandom_range(65, 127);
      configure(mode_data, {bits[7], cnt[6:0]});
      len = $urandom_range(3, 24);
      repeat (len) send_tick(random_color());
   endtask

   task automatic random_phase(input int budget);
      int start;
      start = ticks_sent;
      while (ticks_sent - start < budget) random_segment();
   endtask

   // drive the counter to the top: fade turnaround, then the fill wrap
   task automatic ramp_to_full_scale();
      configure({5'd0, MODE_WIPE}, 8'd2);
      while (counting_down_now) send_tick(random_color());
      configure({5'd0, MODE_FILL}, 8'd2);
      while (frame_count_now < 8'd248) send_tick(random_color());
      configure({5'd0, MODE_FADE}, 8'd2);
      repeat (14) send_tick(random_color());
      configure({5'd0, MODE_FILL}, 8'd2);
      while (frame_count_now < 8'd254) send_tick(random_color());
      repeat (3) send_tick(random_color());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 21;
      rsp_idle_pct <= 58;

      // reset settings: clear on a full strip
      send_tick({8'hFF, 8'h00, 8'hFF});

      // fill on the shortest strip, channel extremes
      configure({5'd0, MODE_FILL}, 8'd2);
      send_tick({8'h00, 8'h00, 8'h00});
      send_tick({8'hFF, 8'hFF, 8'hFF});

      // fade scaling
      configure({5'd0, MODE_FADE}, 8'd3);
      send_tick({8'hFF, 8'h80, 8'h01});
      send_tick({8'hFF, 8'hFF, 8'hFF});
      send_tick({8'h7F, 8'hFE, 8'h02});

      // wipe: counter past the limit is clamped and held, then bounces down to zero
      configure({5'd0, MODE_WIPE}, 8'd2);
      repeat (6) send_tick(random_color());

      // middle on an odd strip, through the empty frame and back
      configure({5'd0, MODE_MIDDLE}, 8'd5);
      repeat (7) send_tick(random_color());

      // unused mode codes and writes to unmapped indexes
      quiesce();
      csr_write(REG_EFFECT_MODE, 8'hFD);
      csr_write(REG_SPARE_2, 8'h5A);
      csr_write(REG_SPARE_3, 8'hA5);
      csr_valid <= 1'b0;
      send_tick({8'hAA, 8'h55, 8'hFF});
      configure(8'h0F, 8'h80);
      send_tick({8'h55, 8'hAA, 8'h00});

      // led count above the strip size saturates
      configure({5'd0, MODE_FILL}, 8'd127);
      send_tick({8'h12, 8'h34, 8'h56});

      random_phase(50);

      // long receiver hold-off while full-strip frames keep coming
      configure({5'd0, MODE_FILL}, 8'd64);
      stall_requests <= stall_requests + 1;
      repeat (8) send_tick(random_color());

      req_idle_pct = 58;
      rsp_idle_pct <= 21;
      random_phase(50);

      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      ramp_to_full_scale();
      random_phase(40);

      quiesce();
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
